// ===== sv/assert_macros.svh =====
// assertion macros shared by the deframer rtl
// every macro samples on posedge clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds on every clock edge
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/shtp_pkg.sv =====
// types, constants and codes shared by the report deframer modules
// no dependencies
`timescale 1ns / 1ps

package shtp_pkg;

    // largest total frame length accepted, header included
    localparam int MAX_FRAME_BYTES = 256;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int HDR_BYTES       = 4;
    localparam int QUAT_MIN_BYTES  = 5 + 8;
    localparam int ACCEL_MIN_BYTES = 5 + 6;
    localparam int TDATA_W         = 120;

    // result kind
    typedef enum logic [1:0] {
        ST_QUAT     = 2'd0,
        ST_ACCEL    = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_BAD_LEN  = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_REPORTS_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_QUAT_ID         = 2'd1;
    localparam logic [1:0] CFG_ACCEL_ID        = 2'd2;

    typedef struct packed {
        logic [7:0] reports_channel;
        logic [7:0] quaternion_report_id;
        logic [7:0] accel_report_id;
    } cfg_t;

    // frame fields as captured, with the end-of-frame event
    typedef struct packed {
        logic               done;
        logic               bad_len;
        logic [15:0]        frame_length;
        logic [7:0]         channel;
        logic [7:0]         report;
        logic [31:0]        timestamp;
        logic [3:0][15:0]   comp;
    } frame_t;

    // one result item
    typedef struct packed {
        status_t            status;
        logic [7:0]         frame_channel_out;
        logic [7:0]         report_code;
        logic [31:0]        timestamp;
        logic signed [15:0] value_i;
        logic signed [15:0] value_j;
        logic signed [15:0] value_k;
        logic signed [15:0] value_real;
        logic [7:0]         payload_length;
    } result_t;

endpackage

// ===== sv/shtp_capture.sv =====
// byte position tracking and header/payload field capture
// depends on shtp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shtp_capture
    import shtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output frame_t     frame
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       len_reg, len_next;
    logic [7:0]        chan_reg, chan_next;
    logic [7:0]        report_reg, report_next;
    logic [31:0]       ts_reg, ts_next;
    logic [3:0][15:0]  comp_reg, comp_next;
    logic              done, bad_len;
    logic [15:0]       pos_ext;
    logic [15:0]       pos_inc;
    logic [POS_W-1:0]  ts_off;
    logic [POS_W-1:0]  comp_off;

    assign pos_ext  = 16'(pos_reg);
    assign pos_inc  = pos_ext + 16'd1;
    assign ts_off   = pos_reg - POS_W'(5);
    assign comp_off = pos_reg - POS_W'(9);

    // next state for one accepted byte
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        chan_next   = chan_reg;
        report_next = report_reg;
        ts_next     = ts_reg;
        comp_next   = comp_reg;
        done        = 1'b0;
        bad_len     = 1'b0;
        priority if (pos_ext == 16'd0)
        begin
            len_next    = {8'd0, rx_byte};
            chan_next   = 8'd0;
            report_next = 8'd0;
            ts_next     = 32'd0;
            comp_next   = '0;
            pos_next    = POS_W'(1);
        end
        else if (pos_ext == 16'd1)
        begin
            len_next = {rx_byte, len_reg[7:0]};
            pos_next = POS_W'(2);
        end
        else if (pos_ext == 16'd2)
        begin
            chan_next = rx_byte;
            pos_next  = POS_W'(3);
        end
        else if (pos_ext == 16'd3)
        begin
            // sequence byte is dropped; length is checked here
            pos_next = '0;
            if (len_reg < 16'(HDR_BYTES) || len_reg > 16'(MAX_FRAME_BYTES))
            begin
                done    = 1'b1;
                bad_len = 1'b1;
            end
            else if (len_reg == 16'(HDR_BYTES))
            begin
                done = 1'b1;
            end
            else
            begin
                pos_next = POS_W'(HDR_BYTES);
            end
        end
        else
        begin
            // payload capture by position
            if (pos_ext == 16'd4)
            begin
                report_next = rx_byte;
            end
            else if (pos_ext <= 16'd8)
            begin
                ts_next[8*ts_off[1:0] +: 8] = rx_byte;
            end
            else if (pos_ext <= 16'd16)
            begin
                comp_next[comp_off[2:1]][8*comp_off[0] +: 8] = rx_byte;
            end
            if (pos_inc >= len_reg)
            begin
                pos_next = '0;
                done     = 1'b1;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    // position is control state, fields are payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg    <= len_next;
            chan_reg   <= chan_next;
            report_reg <= report_next;
            ts_reg     <= ts_next;
            comp_reg   <= comp_next;
        end
    end

    // snapshot handed to the classifier
    always_comb
    begin
        frame.done         = accept && done;
        frame.bad_len      = bad_len;
        frame.frame_length = len_next;
        frame.channel      = chan_next;
        frame.report       = report_next;
        frame.timestamp    = ts_next;
        frame.comp         = comp_next;
    end

    `ASSERT_NEXT(a_done_resyncs, accept && done, pos_reg == '0)
    `ASSERT_IMPL(a_pos_below_len, pos_ext >= 16'(HDR_BYTES), len_reg > pos_ext)

endmodule

// ===== sv/shtp_classify.sv =====
// builds one result item from a finished frame and the configuration
// depends on shtp_pkg
`timescale 1ns / 1ps

module shtp_classify
    import shtp_pkg::*;
(
    input  frame_t  frame,
    input  cfg_t    cfg,
    output result_t result
);

    logic [15:0] plen;
    logic        has_payload;
    logic        with_vals;
    logic        with_real;
    status_t     status;

    assign plen        = frame.frame_length - 16'(HDR_BYTES);
    assign has_payload = (plen != 16'd0);

    // report kind; quaternion id wins when both ids match
    always_comb
    begin
        status    = ST_IGNORED;
        with_vals = 1'b0;
        with_real = 1'b0;
        if (has_payload && frame.channel == cfg.reports_channel)
        begin
            if (frame.report == cfg.quaternion_report_id)
            begin
                if (plen >= 16'(QUAT_MIN_BYTES))
                begin
                    status    = ST_QUAT;
                    with_vals = 1'b1;
                    with_real = 1'b1;
                end
            end
            else if (frame.report == cfg.accel_report_id)
            begin
                if (plen >= 16'(ACCEL_MIN_BYTES))
                begin
                    status    = ST_ACCEL;
                    with_vals = 1'b1;
                end
            end
        end
    end

    // field selection, bad length zeroes everything but the channel and the status
    always_comb
    begin
        result                   = '0;
        result.frame_channel_out = frame.channel;
        if (frame.bad_len)
        begin
            result.status = ST_BAD_LEN;
        end
        else
        begin
            result.status         = status;
            result.report_code    = has_payload ? frame.report : 8'd0;
            result.timestamp      = (plen >= 16'd5) ? frame.timestamp : 32'd0;
            result.value_i        = with_vals ? frame.comp[0] : 16'sd0;
            result.value_j        = with_vals ? frame.comp[1] : 16'sd0;
            result.value_k        = with_vals ? frame.comp[2] : 16'sd0;
            result.value_real     = with_real ? frame.comp[3] : 16'sd0;
            result.payload_length = (plen > 16'd255) ? 8'd255 : plen[7:0];
        end
    end

endmodule

// ===== sv/shtp_out_skid.sv =====
// result register with a one-entry skid stage on the master side
// depends on shtp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shtp_out_skid
    import shtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t in_result,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_result,
    input  logic    out_ready
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_valid)
            begin
                out_reg <= in_result;
            end
        end
        else if (in_valid)
        begin
            skid_reg <= in_result;
        end
    end

    `ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !out_ready))

endmodule

// ===== sv/shtp_report_deframer.sv =====
// Report deframer for the sensor hub transport byte stream.
// Slave side: one stream byte per transfer in s_tdata[7:0]. Master side: one
// result per finished frame, kind in m_tuser, fields in m_tdata. Every frame
// gives exactly one result when its last byte is taken, or after the fourth
// header byte when the length is bad or the payload is empty; other bytes
// give none.
// A byte is taken in every cycle in which s_tvalid is high and the skid
// stage is empty: throughput is one byte per cycle, set by the position
// counter and capture registers, which update in the cycle of the transfer.
// The result of a frame is registered in the result register, or in the skid
// stage when m_tready stalls it. When m_tready is low, one further result is parked in the skid stage and
// s_tready drops only once that stage is full; it rises when the result
// register drains.
// Configuration (cfg_we, cfg_index, cfg_data) writes take effect at the next
// frame end; they must be made while the stream is idle, not enforced here.
// Reset clears the position counter (next byte is the first header byte),
// the output and skid valid flags, and loads the default channel and ids.
`timescale 1ns / 1ps

module shtp_report_deframer
    import shtp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // rx_byte [7:0]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    // frame_channel_out [7:0], report_code [15:8], timestamp [47:16],
    // value_i [63:48], value_j [79:64], value_k [95:80], value_real [111:96],
    // payload_length [119:112]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [1:0]         m_tuser,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    cfg_t    cfg_reg;
    frame_t  frame;
    result_t result;
    result_t out_result;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reports_channel      <= 8'd3;
            cfg_reg.quaternion_report_id <= 8'h28;
            cfg_reg.accel_report_id      <= 8'h01;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPORTS_CHANNEL: cfg_reg.reports_channel      <= cfg_data;
                CFG_QUAT_ID:         cfg_reg.quaternion_report_id <= cfg_data;
                CFG_ACCEL_ID:        cfg_reg.accel_report_id      <= cfg_data;
                default:             cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    shtp_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .frame   (frame)
    );

    shtp_classify u_classify (
        .frame  (frame),
        .cfg    (cfg_reg),
        .result (result)
    );

    shtp_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (frame.done),
        .in_result  (result),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_ready  (m_tready)
    );

    // master side packing
    assign m_tuser = out_result.status;
    assign m_tdata = {out_result.payload_length,
                      out_result.value_real,
                      out_result.value_k,
                      out_result.value_j,
                      out_result.value_i,
                      out_result.timestamp,
                      out_result.report_code,
                      out_result.frame_channel_out};

endmodule

// ===== tb/sv/tb_shtp_report_deframer.sv =====
// testbench for shtp_report_deframer: byte stream in, one checked result per frame out
// depends on shtp_pkg and shtp_report_deframer; needs no files or arguments
`timescale 1ns / 1ps

import shtp_pkg::*;

// tracks the parser state per accepted byte and holds the frame results still owed
class deframe_checker;
    cfg_t        cfg;
    int unsigned pos;
    logic [15:0] total_len;
    logic [7:0]  chan;
    logic [7:0]  report;
    logic [31:0] stamp;
    logic [15:0] comp [4];
    result_t     pending_results [$];
    int unsigned errors;

    function new();
        cfg.reports_channel      = 8'd3;
        cfg.quaternion_report_id = 8'h28;
        cfg.accel_report_id      = 8'h01;
        pos       = 0;
        total_len = '0;
        chan      = '0;
        report    = '0;
        stamp     = '0;
        foreach (comp[n])
            comp[n] = '0;
        errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
        case (idx)
            CFG_REPORTS_CHANNEL: cfg.reports_channel      = v;
            CFG_QUAT_ID:         cfg.quaternion_report_id = v;
            CFG_ACCEL_ID:        cfg.accel_report_id      = v;
            default:             ;
        endcase
    endfunction

    // result of a frame with a legal length, at its end
    function result_t frame_result();
        result_t     r;
        int unsigned plen;
        bit          with_vals;
        bit          with_real;
        plen      = total_len - HDR_BYTES;
        with_vals = 1'b0;
        with_real = 1'b0;
        r         = '0;
        r.status  = ST_IGNORED;
        if (plen > 0 && chan == cfg.reports_channel)
        begin
            if (report == cfg.quaternion_report_id)
            begin
                if (plen >= QUAT_MIN_BYTES)
                begin
                    r.status  = ST_QUAT;
                    with_vals = 1'b1;
                    with_real = 1'b1;
                end
            end
            else if (report == cfg.accel_report_id)
            begin
                if (plen >= ACCEL_MIN_BYTES)
                begin
                    r.status  = ST_ACCEL;
                    with_vals = 1'b1;
                end
            end
        end
        r.frame_channel_out = chan;
        r.report_code       = (plen > 0) ? report : 8'h00;
        r.timestamp         = (plen >= 5) ? stamp : 32'h0;
        r.value_i           = with_vals ? comp[0] : 16'h0;
        r.value_j           = with_vals ? comp[1] : 16'h0;
        r.value_k           = with_vals ? comp[2] : 16'h0;
        r.value_real        = with_real ? comp[3] : 16'h0;
        r.payload_length    = (plen > 255) ? 8'd255 : 8'(plen);
        return r;
    endfunction

    // advance the parser by one accepted byte
    function void absorb_byte(logic [7:0] b);
        int unsigned off;
        result_t     r;
        case (pos)
            0:
            begin
                total_len = {8'h00, b};
                chan      = '0;
                report    = '0;
                stamp     = '0;
                foreach (comp[n])
                    comp[n] = '0;
                pos = 1;
            end
            1:
            begin
                total_len[15:8] = b;
                pos = 2;
            end
            2:
            begin
                chan = b;
                pos  = 3;
            end
            3:
            begin
                // sequence byte, then the length check
                pos = 0;
                if (total_len < HDR_BYTES || total_len > MAX_FRAME_BYTES)
                begin
                    r                   = '0;
                    r.status            = ST_BAD_LEN;
                    r.frame_channel_out = chan;
                    pending_results.push_back(r);
                end
                else if (total_len == HDR_BYTES)
                    pending_results.push_back(frame_result());
                else
                    pos = 4;
            end
            default:
            begin
                off = pos - HDR_BYTES;
                if (off == 0)
                    report = b;
                else if (off <= 4)
                    stamp[8 * (off - 1) +: 8] = b;
                else if (off <= 12)
                begin
                    if (((off - 5) % 2) != 0)
                        comp[(off - 5) / 2][15:8] = b;
                    else
                        comp[(off - 5) / 2][7:0] = b;
                end
                pos++;
                if (pos >= total_len)
                begin
                    pos = 0;
                    pending_results.push_back(frame_result());
                end
            end
        endcase
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            errors++;
        end
    endfunction

    // compare one result transfer with the oldest frame result owed
    function void check_result(logic [TDATA_W-1:0] d, logic [1:0] u);
        result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result with no frame pending: status %0h channel %0h", u, d[7:0]);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("status",            want.status,            u);
        compare_field("frame_channel_out", want.frame_channel_out, d[7:0]);
        compare_field("report_code",       want.report_code,       d[15:8]);
        compare_field("timestamp",         want.timestamp,         d[47:16]);
        compare_field("value_i",           want.value_i[15:0],     d[63:48]);
        compare_field("value_j",           want.value_j[15:0],     d[79:64]);
        compare_field("value_k",           want.value_k[15:0],     d[95:80]);
        compare_field("value_real",        want.value_real[15:0],  d[111:96]);
        compare_field("payload_length",    want.payload_length,    d[119:112]);
    endfunction
endclass

module tb_shtp_report_deframer;
    import shtp_pkg::*;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam logic [7:0] DEF_CHANNEL  = 8'd3;
    localparam logic [7:0] DEF_QUAT_ID  = 8'h28;
    localparam logic [7:0] DEF_ACCEL_ID = 8'h01;
    localparam int FILL_RANDOM  = -1;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_MOSTLY,
        RDY_PERIODIC
    } ready_mode_e;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;

    deframe_checker chk;
    int             burst_left   = 0;
    int             gap_left     = 0;
    int             bytes_sent   = 0;
    int             cycle_count  = 0;
    bit             hold_request = 1'b0;

    shtp_report_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL shtp_report_deframer");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            chk.check_result(m_tdata, m_tuser);
    end

    // receiver: stall pattern in one of four modes, picked anew at random, plus long hold-offs
    initial
    begin
        ready_mode_e mode;
        int          span;
        m_tready = 1'b0;
        mode     = RDY_ALWAYS;
        span     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = ready_mode_e'($urandom_range(0, 3));
                    span = $urandom_range(30, 200);
                end
                span--;
                case (mode)
                    RDY_ALWAYS:   m_tready <= 1'b1;
                    RDY_HALF:     m_tready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                    default:      m_tready <= ((span % 5) != 0);
                endcase
            end
        end
    end

    // one byte transfer, with bursts and gaps on the sender side
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        repeat (gap_left)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        gap_left = 0;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        chk.absorb_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    // header, then the payload when the length is legal
    task automatic send_frame(input logic [15:0] total, input logic [7:0] ch,
                              input logic [7:0] rid, input int fill);
        send_byte(total[7:0]);
        send_byte(total[15:8]);
        send_byte(ch);
        send_byte(8'($urandom));
        if (total > HDR_BYTES && total <= MAX_FRAME_BYTES)
        begin
            send_byte(rid);
            for (int n = 1; n < total - HDR_BYTES; n++)
                send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
        end
    endtask

    // random bytes until the parser expects a header again
    task automatic flush_frame();
        while (chk.pos != 0)
            send_byte(8'($urandom));
    endtask

    // stop sending and wait until every frame result has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (chk.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        chk.write_reg(idx, v);
    endtask

    // mostly well-formed report frames, some odd ones and some line noise
    task automatic send_random_frame();
        int          pick;
        logic [7:0]  ch;
        logic [7:0]  qid;
        logic [7:0]  aid;
        logic [15:0] total;
        pick = $urandom_range(0, 99);
        ch   = chk.cfg.reports_channel;
        qid  = chk.cfg.quaternion_report_id;
        aid  = chk.cfg.accel_report_id;
        if (pick < 30)
            send_frame(16'(4 + $urandom_range(13, 24)), ch, qid, FILL_RANDOM);
        else if (pick < 55)
            send_frame(16'(4 + $urandom_range(11, 20)), ch, aid, FILL_RANDOM);
        else if (pick < 59)
            send_frame(16'(4 + $urandom_range(1, 12)), ch, qid, FILL_RANDOM);
        else if (pick < 63)
            send_frame(16'(4 + $urandom_range(1, 10)), ch, aid, FILL_RANDOM);
        else if (pick < 75)
            send_frame(16'(4 + $urandom_range(0, 20)), 8'($urandom),
                       ($urandom_range(0, 1) != 0) ? qid : aid, FILL_RANDOM);
        else if (pick < 81)
            send_frame(16'(4 + $urandom_range(1, 20)), ch, 8'($urandom), FILL_RANDOM);
        else if (pick < 86)
            send_frame(16'd4, 8'($urandom), 8'h00, FILL_RANDOM);
        else if (pick < 93)
        begin
            if ($urandom_range(0, 1) != 0)
                total = 16'($urandom_range(0, 3));
            else
                total = 16'($urandom_range(MAX_FRAME_BYTES + 1, 65535));
            send_frame(total, 8'($urandom), 8'h00, FILL_RANDOM);
        end
        else if (pick < 95)
            send_frame(16'(4 + $urandom_range(100, 252)), ch,
                       ($urandom_range(0, 1) != 0) ? qid : aid, FILL_RANDOM);
        else
        begin
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom));
            flush_frame();
        end
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_frame();
        flush_frame();
        drain();
    endtask

    // main sequence
    initial
    begin
        chk       = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_we    = 1'b0;
        cfg_index = CFG_REPORTS_CHANNEL;
        cfg_data  = 8'h00;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed frames at the reset settings
        send_frame(16'd4, DEF_CHANNEL, 8'h00, FILL_RANDOM);
        send_frame(16'd3, 8'h00, 8'h00, FILL_RANDOM);
        send_frame(16'd0, 8'hFF, 8'h00, FILL_RANDOM);
        send_frame(16'd257, DEF_CHANNEL, 8'h00, FILL_RANDOM);
        send_frame(16'hFFFF, DEF_CHANNEL, 8'h00, FILL_RANDOM);
        send_frame(16'd17, DEF_CHANNEL, DEF_QUAT_ID, 8'hFF);
        send_frame(16'd17, DEF_CHANNEL, DEF_QUAT_ID, 8'h00);
        send_frame(16'd17, DEF_CHANNEL, DEF_QUAT_ID, 8'h80);
        send_frame(16'd17, DEF_CHANNEL, DEF_QUAT_ID, 8'h7F);
        send_frame(16'd16, DEF_CHANNEL, DEF_QUAT_ID, FILL_RANDOM);
        send_frame(16'd15, DEF_CHANNEL, DEF_ACCEL_ID, FILL_RANDOM);
        send_frame(16'd15, DEF_CHANNEL, DEF_ACCEL_ID, 8'hFF);
        send_frame(16'd14, DEF_CHANNEL, DEF_ACCEL_ID, FILL_RANDOM);
        send_frame(16'd5, DEF_CHANNEL, DEF_QUAT_ID, FILL_RANDOM);
        send_frame(16'd8, DEF_CHANNEL, DEF_QUAT_ID, FILL_RANDOM);
        send_frame(16'd9, DEF_CHANNEL, DEF_ACCEL_ID, FILL_RANDOM);
        send_frame(16'd256, DEF_CHANNEL, DEF_ACCEL_ID, FILL_RANDOM);
        send_frame(16'd17, 8'd4, DEF_QUAT_ID, FILL_RANDOM);
        send_frame(16'd17, DEF_CHANNEL, 8'h29, FILL_RANDOM);
        send_frame(16'd30, DEF_CHANNEL, DEF_QUAT_ID, FILL_RANDOM);
        drain();

        // low extremes, with a long receiver hold-off
        write_reg(CFG_REPORTS_CHANNEL, 8'h00);
        write_reg(CFG_QUAT_ID, 8'h00);
        write_reg(CFG_ACCEL_ID, 8'hFF);
        hold_request = 1'b1;
        run_random(260);

        // shared report id: the quaternion rule wins, short payloads are ignored
        write_reg(CFG_REPORTS_CHANNEL, 8'hFF);
        write_reg(CFG_QUAT_ID, 8'h5A);
        write_reg(CFG_ACCEL_ID, 8'h5A);
        send_frame(16'd15, 8'hFF, 8'h5A, FILL_RANDOM);
        send_frame(16'd16, 8'hFF, 8'h5A, FILL_RANDOM);
        send_frame(16'd17, 8'hFF, 8'h5A, FILL_RANDOM);
        run_random(260);

        // high extremes
        write_reg(CFG_QUAT_ID, 8'hFF);
        write_reg(CFG_ACCEL_ID, 8'h00);
        run_random(230);

        // random settings, a write to the unused index, another hold-off
        write_reg(CFG_REPORTS_CHANNEL, 8'($urandom));
        write_reg(CFG_QUAT_ID, 8'($urandom));
        write_reg(CFG_ACCEL_ID, 8'($urandom));
        write_reg(CFG_UNUSED, 8'($urandom));
        hold_request = 1'b1;
        run_random(280);

        if (chk.errors == 0 && chk.pending_results.size() == 0)
            $display("PASS shtp_report_deframer");
        else
            $display("FAIL shtp_report_deframer");
        $finish;
    end

endmodule
